// ===== rtl/core/das_pkg.sv =====
// Shared constants and derived widths for the decimating average smoother.
package das_pkg;

  // Sample format and block sizes.
  localparam int SAMPLE_BITS = 10;
  localparam int BLOCK_LEN   = 500;
  localparam int TAPS        = 10;
  localparam int OUT_W       = 10;

  // Smoothing weights: new = (old * 8 + average * 2) / 10.
  localparam int SMOOTH_OLD = 8;
  localparam int SMOOTH_NEW = 2;
  localparam int SMOOTH_DIV = 10;

  localparam longint SAMPLE_MAX = (longint'(1) << SAMPLE_BITS) - 1;

  // Block accumulator and sample counter.
  localparam int ACC_W = $clog2(SAMPLE_MAX * BLOCK_LEN + 1);
  localparam int CNT_W = $clog2(BLOCK_LEN + 1);

  // Exact division of the block total by BLOCK_LEN: multiply by a rounded-up
  // reciprocal and keep the bits above BDIV_SH.
  localparam int     BDIV_SH = ACC_W + $clog2(BLOCK_LEN);
  localparam longint BDIV_M  = ((longint'(1) << BDIV_SH) + BLOCK_LEN - 1) / BLOCK_LEN;
  localparam int     BPROD_W = BDIV_SH + SAMPLE_BITS;

  // Sum of the delay line and its division by TAPS.
  localparam int     SUM_W   = $clog2(SAMPLE_MAX * TAPS + 1);
  localparam int     TDIV_SH = SUM_W + $clog2(TAPS);
  localparam longint TDIV_M  = ((longint'(1) << TDIV_SH) + TAPS - 1) / TAPS;
  localparam int     TPROD_W = TDIV_SH + SAMPLE_BITS;

  // Weighted mix for the smoother and its division by SMOOTH_DIV.
  localparam int     MIX_W   = $clog2(SAMPLE_MAX * (SMOOTH_OLD + SMOOTH_NEW) + 1);
  localparam int     SDIV_SH = MIX_W + $clog2(SMOOTH_DIV);
  localparam longint SDIV_M  = ((longint'(1) << SDIV_SH) + SMOOTH_DIV - 1) / SMOOTH_DIV;
  localparam int     SPROD_W = SDIV_SH + SAMPLE_BITS;

  typedef logic [SAMPLE_BITS-1:0] sample_t;

endpackage

// ===== rtl/core/decimating_average_smoother_unit.sv =====
// The last sample of a block passes the input register, then the total, mean, sum, average and result registers.
// Throughput: one sample per cycle while the input is not stalled; one result per BLOCK_LEN samples.
// The rate is set by the accumulator update; later stages only see block ends.
// The input stalls only while a result waits and every stage behind it holds a block end.
// Synchronous active-low reset clears the accumulator, counter, delay line and smoother.
module decimating_average_smoother_unit import das_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  sample_t          in_sample,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [OUT_W-1:0] out_block_mean,
  output logic [OUT_W-1:0] out_moving_avg,
  output logic [OUT_W-1:0] out_smoothed
);

  logic             tot_vld;
  logic [ACC_W-1:0] tot;
  logic             hist_hold;
  logic             avg_vld;
  sample_t          avg;
  sample_t          mean;
  logic             smooth_hold;

  // Accumulation of each block.
  das_accum u_accum (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_sample (in_sample),
    .tot_vld   (tot_vld),
    .tot       (tot),
    .dn_hold   (hist_hold)
  );

  // Block mean, delay line and moving average.
  das_hist u_hist (
    .clk     (clk),
    .rst_n   (rst_n),
    .tot_vld (tot_vld),
    .tot     (tot),
    .up_hold (hist_hold),
    .avg_vld (avg_vld),
    .avg     (avg),
    .mean    (mean),
    .dn_hold (smooth_hold)
  );

  // Smoother and result register.
  das_smooth u_smooth (
    .clk            (clk),
    .rst_n          (rst_n),
    .avg_vld        (avg_vld),
    .avg            (avg),
    .mean           (mean),
    .up_hold        (smooth_hold),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_block_mean (out_block_mean),
    .out_moving_avg (out_moving_avg),
    .out_smoothed   (out_smoothed)
  );

endmodule

// ===== rtl/core/das_accum.sv =====
// Input register, block accumulator and sample counter.
module das_accum import das_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  sample_t          in_sample,
  output logic             tot_vld,
  output logic [ACC_W-1:0] tot,
  input  logic             dn_hold
);

  logic             in_vld_r;
  sample_t          smp_r;
  logic [ACC_W-1:0] acc_r;
  logic [CNT_W-1:0] cnt_r;
  logic             tot_vld_r;
  logic [ACC_W-1:0] tot_r;
  logic [ACC_W-1:0] acc_nxt;
  logic             tot_hold;
  logic             in_hold;
  logic             fire;
  logic             last;

  // The total register holds while the next stage is blocked; the sample
  // register holds behind it.
  assign tot_hold = tot_vld_r & dn_hold;
  assign in_hold  = in_vld_r & tot_hold;
  assign in_stall = in_hold;
  assign fire     = in_vld_r & ~in_hold;
  assign last     = (cnt_r == CNT_W'(BLOCK_LEN - 1));
  assign acc_nxt  = acc_r + ACC_W'(smp_r);

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_hold) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      smp_r <= in_sample;
    end
  end

  // Accumulate; the last sample of a block hands the total on and clears.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
      cnt_r <= '0;
    end else if (fire) begin
      if (last) begin
        acc_r <= '0;
        cnt_r <= '0;
      end else begin
        acc_r <= acc_nxt;
        cnt_r <= cnt_r + CNT_W'(1);
      end
    end
  end

  // Block total register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tot_vld_r <= 1'b0;
    end else if (!tot_hold) begin
      tot_vld_r <= fire & last;
    end
  end

  always_ff @(posedge clk) begin
    if (!tot_hold && fire && last) begin
      tot_r <= acc_nxt;
    end
  end

  assign tot_vld = tot_vld_r;
  assign tot     = tot_r;

endmodule

// ===== rtl/core/das_hist.sv =====
// Block mean, delay line of means and moving average, over three stages.
module das_hist import das_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             tot_vld,
  input  logic [ACC_W-1:0] tot,
  output logic             up_hold,
  output logic             avg_vld,
  output sample_t          avg,
  output sample_t          mean,
  input  logic             dn_hold
);

  logic               mean_vld_r;
  sample_t            mean_r;
  sample_t            hist_r [TAPS];
  logic               sum_vld_r;
  logic [SUM_W-1:0]   sum_r;
  sample_t            mean3_r;
  logic               avg_vld_r;
  sample_t            avg_r;
  sample_t            mean4_r;
  logic [BPROD_W-1:0] bprod;
  logic [TPROD_W-1:0] tprod;
  logic [SUM_W-1:0]   sum_nxt;
  logic               s2_hold;
  logic               s3_hold;
  logic               s4_hold;

  // A stage holds when it is full and the stage after it holds.
  assign s4_hold = avg_vld_r & dn_hold;
  assign s3_hold = sum_vld_r & s4_hold;
  assign s2_hold = mean_vld_r & s3_hold;
  assign up_hold = s2_hold;

  // Block mean by reciprocal multiplication.
  assign bprod = BPROD_W'(tot) * BPROD_W'(BDIV_M);

  // Sum of the delay line after the latest shift.
  always_comb begin
    sum_nxt = '0;
    for (int i = 0; i < TAPS; i++) begin
      sum_nxt = sum_nxt + SUM_W'(hist_r[i]);
    end
  end

  // Moving average by reciprocal multiplication.
  assign tprod = TPROD_W'(sum_r) * TPROD_W'(TDIV_M);

  // Mean stage: the new mean enters the delay line, oldest entry drops out.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mean_vld_r <= 1'b0;
      for (int i = 0; i < TAPS; i++) begin
        hist_r[i] <= '0;
      end
    end else if (!s2_hold) begin
      mean_vld_r <= tot_vld;
      if (tot_vld) begin
        for (int i = 0; i < TAPS - 1; i++) begin
          hist_r[i] <= hist_r[i+1];
        end
        hist_r[TAPS-1] <= bprod[BDIV_SH +: SAMPLE_BITS];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!s2_hold && tot_vld) begin
      mean_r <= bprod[BDIV_SH +: SAMPLE_BITS];
    end
  end

  // Sum stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_vld_r <= 1'b0;
    end else if (!s3_hold) begin
      sum_vld_r <= mean_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!s3_hold && mean_vld_r) begin
      sum_r   <= sum_nxt;
      mean3_r <= mean_r;
    end
  end

  // Average stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      avg_vld_r <= 1'b0;
    end else if (!s4_hold) begin
      avg_vld_r <= sum_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!s4_hold && sum_vld_r) begin
      avg_r   <= tprod[TDIV_SH +: SAMPLE_BITS];
      mean4_r <= mean3_r;
    end
  end

  assign avg_vld = avg_vld_r;
  assign avg     = avg_r;
  assign mean    = mean4_r;

endmodule

// ===== rtl/core/das_smooth.sv =====
// Exponential smoother and result register.
module das_smooth import das_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             avg_vld,
  input  sample_t          avg,
  input  sample_t          mean,
  output logic             up_hold,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [OUT_W-1:0] out_block_mean,
  output logic [OUT_W-1:0] out_moving_avg,
  output logic [OUT_W-1:0] out_smoothed
);

  logic               out_vld_r;
  sample_t            sm_r;
  sample_t            mean_o_r;
  sample_t            avg_o_r;
  logic [MIX_W-1:0]   mix;
  logic [SPROD_W-1:0] sprod;
  logic               out_hold;

  // The result register holds while a result waits to be taken.
  assign out_hold = out_vld_r & out_stall;
  assign up_hold  = out_hold;

  // Weighted mix of the previous value and the new average, then divide.
  assign mix   = MIX_W'(sm_r) * MIX_W'(SMOOTH_OLD) + MIX_W'(avg) * MIX_W'(SMOOTH_NEW);
  assign sprod = SPROD_W'(mix) * SPROD_W'(SDIV_M);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
      sm_r      <= '0;
    end else if (!out_hold) begin
      out_vld_r <= avg_vld;
      if (avg_vld) begin
        sm_r <= sprod[SDIV_SH +: SAMPLE_BITS];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_hold && avg_vld) begin
      mean_o_r <= mean;
      avg_o_r  <= avg;
    end
  end

  assign out_valid      = out_vld_r;
  assign out_block_mean = OUT_W'(mean_o_r);
  assign out_moving_avg = OUT_W'(avg_o_r);
  assign out_smoothed   = OUT_W'(sm_r);

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for the decimating average smoother unit.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import das_pkg::*;

  localparam int          IDLE_LIMIT   = 6000;
  localparam int          DRAIN_CYCLES = 20;
  localparam int          HOLD_CYCLES  = 4000;
  localparam int unsigned SAMPLE_TOP   = 32'(SAMPLE_MAX);

  typedef struct packed {
    logic [OUT_W-1:0] block_mean;
    logic [OUT_W-1:0] moving_avg;
    logic [OUT_W-1:0] smoothed;
  } smoother_result_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  sample_t          in_sample = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [OUT_W-1:0] out_block_mean;
  logic [OUT_W-1:0] out_moving_avg;
  logic [OUT_W-1:0] out_smoothed;

  // Predicted filter state.
  int unsigned      block_sum;
  int unsigned      block_taken;
  logic [OUT_W-1:0] mean_line [TAPS];
  logic [OUT_W-1:0] smooth_level;
  smoother_result_t expected_results [$];

  // Stimulus and checking bookkeeping.
  int mismatches   = 0;
  int idle_cycles  = 0;
  bit tx_gaps      = 1'b0;
  int burst_left   = 0;
  bit rx_pacing    = 1'b0;
  int hold_left    = 0;
  int stall_run    = 0;
  bit stall_phase  = 1'b0;

  decimating_average_smoother_unit u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_sample      (in_sample),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_block_mean (out_block_mean),
    .out_moving_avg (out_moving_avg),
    .out_smoothed   (out_smoothed)
  );

  always #10 clk = ~clk;

  // Clear the predicted state to match the block after reset.
  function automatic void clear_filter_state();
    block_sum    = 0;
    block_taken  = 0;
    smooth_level = '0;
    foreach (mean_line[i]) mean_line[i] = '0;
  endfunction

  // Fold one accepted sample into the predicted state; a block end yields a result.
  function automatic void absorb_sample(input sample_t s);
    int unsigned      line_total;
    smoother_result_t r;
    block_sum += 32'(s);
    block_taken++;
    if (block_taken == BLOCK_LEN) begin
      r.block_mean = OUT_W'(block_sum / BLOCK_LEN);
      block_sum    = 0;
      block_taken  = 0;
      line_total   = 0;
      for (int i = 0; i < TAPS - 1; i++) begin
        mean_line[i] = mean_line[i + 1];
        line_total  += 32'(mean_line[i]);
      end
      mean_line[TAPS - 1] = r.block_mean;
      line_total         += 32'(r.block_mean);
      r.moving_avg  = OUT_W'(line_total / TAPS);
      smooth_level  = OUT_W'((int'(smooth_level) * SMOOTH_OLD
                              + int'(r.moving_avg) * SMOOTH_NEW) / SMOOTH_DIV);
      r.smoothed    = smooth_level;
      expected_results.push_back(r);
    end
  endfunction

  // Compare one result transfer against the oldest prediction.
  function automatic void check_result();
    smoother_result_t want;
    if (expected_results.size() == 0) begin
      $error("unexpected result: block_mean %0d moving_avg %0d smoothed %0d",
             out_block_mean, out_moving_avg, out_smoothed);
      mismatches++;
    end else begin
      want = expected_results.pop_front();
      if (out_block_mean !== want.block_mean) begin
        $error("block_mean: expected %0d, got %0d", want.block_mean, out_block_mean);
        mismatches++;
      end
      if (out_moving_avg !== want.moving_avg) begin
        $error("moving_avg: expected %0d, got %0d", want.moving_avg, out_moving_avg);
        mismatches++;
      end
      if (out_smoothed !== want.smoothed) begin
        $error("smoothed: expected %0d, got %0d", want.smoothed, out_smoothed);
        mismatches++;
      end
    end
  endfunction

  // Sample both channels at the rising edge.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) check_result();
    if (rst_n && in_valid && !in_stall) absorb_sample(in_sample);
  end

  // Watchdog: too long without any transfer ends the run.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Receiver: a long hold-off when requested, otherwise random runs of stall and flow.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (rx_pacing) begin
      if (stall_run == 0) begin
        stall_phase = ($urandom_range(0, 2) == 0);
        stall_run   = $urandom_range(1, 12);
      end
      stall_run--;
      out_stall <= stall_phase;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Offer one sample and hold it until the transfer; bursts are broken by random gaps.
  task automatic send_sample(input sample_t s);
    int gap;
    if (tx_gaps && burst_left <= 0) begin
      gap        = $urandom_range(1, 8);
      burst_left = $urandom_range(1, 60);
      @(negedge clk);
      in_valid  <= 1'b0;
      in_sample <= sample_t'($urandom);
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid  <= 1'b1;
    in_sample <= s;
    do @(posedge clk); while (in_stall);
    burst_left--;
  endtask

  // Stop offering and wait until every predicted result has arrived.
  task automatic settle_stream();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // Warm-up: an all-zero block with the delay line still empty.
  task automatic test_warmup_zero_block();
    tx_gaps   = 1'b0;
    rx_pacing = 1'b0;
    repeat (BLOCK_LEN) send_sample('0);
    settle_stream();
  endtask

  // Block sums just short of a multiple of the block length must truncate downwards.
  task automatic test_truncation_edges();
    tx_gaps   = 1'b1;
    rx_pacing = 1'b1;
    repeat (BLOCK_LEN - 1) send_sample(sample_t'(1));
    send_sample('0);
    repeat (BLOCK_LEN - 1) send_sample(sample_t'(SAMPLE_TOP));
    send_sample(sample_t'(SAMPLE_TOP - 1));
    settle_stream();
  endtask

  // Full-scale blocks until the delay line holds only the largest mean.
  task automatic test_full_scale();
    tx_gaps   = 1'b0;
    rx_pacing = 1'b1;
    repeat ((TAPS + 2) * BLOCK_LEN) send_sample(sample_t'(SAMPLE_TOP));
    settle_stream();
  endtask

  // Random blocks, each drawn from its own random band, with idling switched per block.
  task automatic test_random_blocks();
    int unsigned lo;
    int unsigned hi;
    repeat (40) begin
      tx_gaps   = ($urandom_range(0, 3) != 0);
      rx_pacing = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 3) == 0) begin
        lo = 0;
        hi = SAMPLE_TOP;
      end else begin
        lo = $urandom_range(0, SAMPLE_TOP);
        hi = $urandom_range(lo, SAMPLE_TOP);
      end
      repeat (BLOCK_LEN) send_sample(sample_t'($urandom_range(lo, hi)));
    end
    settle_stream();
  endtask

  // The receiver holds off while samples keep coming, so four block ends pile up
  // behind the waiting result and the block must stall its input.
  task automatic test_output_backpressure();
    tx_gaps   = 1'b0;
    rx_pacing = 1'b0;
    @(negedge clk);
    hold_left = HOLD_CYCLES;
    repeat (6 * BLOCK_LEN) send_sample(sample_t'($urandom));
    settle_stream();
  endtask

  initial begin
    clear_filter_state();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_warmup_zero_block();
    test_truncation_edges();
    test_full_scale();
    test_random_blocks();
    test_output_backpressure();

    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
